FILE: hw/rtl/q_table_update_engine_assert.svh
// ----------------------------------------------------------------------------
// Q table update engine assertion macros
// Shared property wrappers for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef Q_TABLE_UPDATE_ENGINE_ASSERT_SVH
`define Q_TABLE_UPDATE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define QTUE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("q_table_update_engine: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define QTUE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("q_table_update_engine: next-cycle check failed");

// Invariant that holds at every edge out of reset
`define QTUE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("q_table_update_engine: invariant failed");

`endif

FILE: hw/rtl/qtue_pkg.sv
// ----------------------------------------------------------------------------
// qtue_pkg
// Shared widths, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package qtue_pkg;

   // Fixed field widths
   localparam int COORD_W    = 4;
   localparam int MOVE_W     = 2;
   localparam int MASK_W     = 4;
   localparam int VALUE_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   // Grid dimension compare width (dimensions up to 256)
   localparam int DIM_W = 9;
   // Action count compare width (up to 8 actions)
   localparam int NACT_W = 4;

   // Moves covered by the mask field
   localparam int MASK_MOVES = 4;

   // Arithmetic widths
   localparam int PROD1_W = FRAC_W + 1 + VALUE_W;     // gamma * best
   localparam int GB_W    = PROD1_W - FRAC_W;         // rounded gamma * best
   localparam int DIFF_W  = VALUE_W + 2;              // reward + gb - q
   localparam int PROD2_W = FRAC_W + 1 + DIFF_W;      // alpha * diff
   localparam int STEP_W  = PROD2_W - FRAC_W;         // rounded step
   localparam int SUM_W   = STEP_W + 1;               // q + step

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] LEARNING_RATE_RST   = 16'd6554;
   localparam logic [CSR_DATA_W-1:0] DISCOUNT_FACTOR_RST = 16'd58982;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT_FACTOR = 2'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic              start;     // capture the accepted item
      logic              clear;     // write zero at the sweep address
      logic              rd_next;   // read one next-cell entry
      logic              rd_cur;    // read the current entry
      logic              mul1;      // gamma * best
      logic              diff;      // reward + gb - q
      logic              mul2;      // alpha * diff
      logic              commit;    // write back and load the result
      logic [MOVE_W-1:0] move_idx;  // next-cell move being read
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic req_bad;     // offered item has no usable move
      logic clear_last;  // sweep sits at the last entry
   } status_type;

endpackage

FILE: hw/rtl/q_table_update_engine.sv
// Flow: an accepted item passes through the next-cell reads, the Q(s,a) read, three
// arithmetic steps and write-back; a refused item goes straight to write-back. Write-back
// waits while the previous result still waits for its transfer. A new item is taken
// only once the engine is back in idle after the write-back of the last one.
// Reset: registers return to defaults, then a clearing pass zeroes all
// GRID_ROWS*GRID_COLS*NUM_ACTIONS entries of the table.
// ----------------------------------------------------------------------------
// q_table_update_engine
// Tabular Q-learning update over a grid Q table in signed 16.16 fixed point.
// ----------------------------------------------------------------------------
`include "q_table_update_engine_assert.svh"

module q_table_update_engine import qtue_pkg::*; #(
   parameter int GRID_ROWS   = 16,
   parameter int GRID_COLS   = 16,
   parameter int NUM_ACTIONS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [COORD_W-1:0]        req_cur_row,
   input  logic [COORD_W-1:0]        req_cur_col,
   input  logic [MOVE_W-1:0]         req_action,
   input  logic [COORD_W-1:0]        req_next_row,
   input  logic [COORD_W-1:0]        req_next_col,
   input  logic signed [VALUE_W-1:0] req_reward_value,
   input  logic [MASK_W-1:0]         req_next_move_mask,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_updated_value,
   output logic signed [VALUE_W-1:0] rsp_best_future,
   output logic                      rsp_mask_error
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   qtue_ctrl #(
      .NUM_ACTIONS(NUM_ACTIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table and arithmetic
   qtue_datapath #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .NUM_ACTIONS(NUM_ACTIONS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_cur_row        (req_cur_row),
      .req_cur_col        (req_cur_col),
      .req_action         (req_action),
      .req_next_row       (req_next_row),
      .req_next_col       (req_next_col),
      .req_reward_value   (req_reward_value),
      .req_next_move_mask (req_next_move_mask),
      .cmd                (cmd),
      .status             (status),
      .rsp_updated_value  (rsp_updated_value),
      .rsp_best_future    (rsp_best_future),
      .rsp_mask_error     (rsp_mask_error)
   );

   // One item in flight: the input side closes after a transfer
   `QTUE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // A commit always leaves a result waiting
   `QTUE_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_valid)
   // No item is taken during the clearing pass
   `QTUE_ASSERT_NOW(a_no_accept_in_clear, clock, reset, cmd.clear, !req_ready)
   // Sequencer issues at most one step per cycle
   `QTUE_ASSERT_ALWAYS(a_one_step, clock, reset,
      $onehot0({cmd.start, cmd.clear, cmd.rd_next, cmd.rd_cur,
                cmd.mul1, cmd.diff, cmd.mul2, cmd.commit}))

endmodule

FILE: hw/rtl/qtue_ctrl.sv
// ----------------------------------------------------------------------------
// qtue_ctrl
// Sequencer: clearing sweep, next-cell reads, arithmetic steps, result hold.
// ----------------------------------------------------------------------------
module qtue_ctrl import qtue_pkg::*; #(
   parameter int NUM_ACTIONS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int NA_EFF = (NUM_ACTIONS < MASK_MOVES) ? NUM_ACTIONS : MASK_MOVES;
   localparam logic [MOVE_W-1:0] LAST_MOVE = MOVE_W'(NA_EFF - 1);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_READ_NEXT = 3'd2;
   localparam logic [2:0] S_READ_CUR  = 3'd3;
   localparam logic [2:0] S_MUL1      = 3'd4;
   localparam logic [2:0] S_DIFF      = 3'd5;
   localparam logic [2:0] S_MUL2      = 3'd6;
   localparam logic [2:0] S_WRITE     = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [MOVE_W-1:0] move_ff, move_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      move_in  = move_ff;
      cmd      = '0;
      cmd.move_idx = move_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               move_in   = '0;
               state_in  = status.req_bad ? S_WRITE : S_READ_NEXT;
            end
         end
         S_READ_NEXT: begin
            cmd.rd_next = 1'b1;
            move_in     = move_ff + 1'b1;
            if (move_ff == LAST_MOVE) begin
               state_in = S_READ_CUR;
            end
         end
         S_READ_CUR: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Result valid: set on commit, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         move_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         move_ff      <= move_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/qtue_datapath.sv
// ----------------------------------------------------------------------------
// qtue_datapath
// Q table memory, item registers, best-value search and fixed-point update.
// ----------------------------------------------------------------------------
module qtue_datapath import qtue_pkg::*; #(
   parameter int GRID_ROWS   = 16,
   parameter int GRID_COLS   = 16,
   parameter int NUM_ACTIONS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data,
   input  logic [COORD_W-1:0]        req_cur_row,
   input  logic [COORD_W-1:0]        req_cur_col,
   input  logic [MOVE_W-1:0]         req_action,
   input  logic [COORD_W-1:0]        req_next_row,
   input  logic [COORD_W-1:0]        req_next_col,
   input  logic signed [VALUE_W-1:0] req_reward_value,
   input  logic [MASK_W-1:0]         req_next_move_mask,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic signed [VALUE_W-1:0] rsp_updated_value,
   output logic signed [VALUE_W-1:0] rsp_best_future,
   output logic                      rsp_mask_error
);

   localparam int DEPTH  = GRID_ROWS * GRID_COLS * NUM_ACTIONS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NA_EFF = (NUM_ACTIONS < MASK_MOVES) ? NUM_ACTIONS : MASK_MOVES;
   localparam logic [MASK_W-1:0] MASK_KEEP = MASK_W'((1 << NA_EFF) - 1);
   localparam logic [DIM_W-1:0]  ROWS_LIM  = DIM_W'(GRID_ROWS);
   localparam logic [DIM_W-1:0]  COLS_LIM  = DIM_W'(GRID_COLS);
   localparam logic [NACT_W-1:0] NACT_LIM  = NACT_W'(NUM_ACTIONS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // Configuration
   logic [CSR_DATA_W-1:0] lr_ff, lr_in;
   logic [CSR_DATA_W-1:0] df_ff, df_in;

   // Item registers
   logic [ADDR_W-1:0]         nbase_ff;
   logic [ADDR_W-1:0]         cidx_ff;
   logic signed [VALUE_W-1:0] reward_ff;
   logic [MASK_W-1:0]         mask_ff;
   logic                      err_ff;

   // Memory
   logic [VALUE_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [ADDR_W-1:0]  raddr;
   logic [ADDR_W-1:0]  waddr;
   logic [VALUE_W-1:0] wdata;
   logic               rd_en;
   logic               wr_en;
   logic [VALUE_W-1:0] rdata_ff;

   // Search
   logic              rd_next_ff;
   logic [MOVE_W-1:0] rd_move_ff;
   logic              found_ff;
   logic signed [VALUE_W-1:0] best_ff;
   logic              take;

   // Arithmetic
   logic signed [VALUE_W-1:0] q_ff;
   logic signed [PROD1_W-1:0] prod1_ff, prod1_in, prod1_rnd;
   logic signed [GB_W-1:0]    gb;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [PROD2_W-1:0] prod2_ff, prod2_in, prod2_rnd;
   logic signed [STEP_W-1:0]  step;
   logic signed [SUM_W-1:0]   sum;
   logic signed [VALUE_W-1:0] new_val;

   // Output registers
   logic signed [VALUE_W-1:0] upd_out_ff;
   logic signed [VALUE_W-1:0] best_out_ff;
   logic                      err_out_ff;

   // Offered item checks and addresses
   logic              req_ok;
   logic [MASK_W-1:0] req_mask_eff;
   logic [ADDR_W-1:0] req_ncell;
   logic [ADDR_W-1:0] req_ccell;

   // Register writes
   always_comb begin
      lr_in = lr_ff;
      df_in = df_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:   lr_in = csr_wr_data;
            CSR_DISCOUNT_FACTOR: df_in = csr_wr_data;
            default: begin
               lr_in = lr_ff;
               df_in = df_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= LEARNING_RATE_RST;
         df_ff <= DISCOUNT_FACTOR_RST;
      end else begin
         lr_ff <= lr_in;
         df_ff <= df_in;
      end
   end

   // Check the offered item and form its table addresses
   always_comb begin
      req_mask_eff = req_next_move_mask & MASK_KEEP;
      req_ok = ({{(DIM_W-COORD_W){1'b0}}, req_cur_row}  < ROWS_LIM) &&
               ({{(DIM_W-COORD_W){1'b0}}, req_cur_col}  < COLS_LIM) &&
               ({{(DIM_W-COORD_W){1'b0}}, req_next_row} < ROWS_LIM) &&
               ({{(DIM_W-COORD_W){1'b0}}, req_next_col} < COLS_LIM) &&
               ({{(NACT_W-MOVE_W){1'b0}}, req_action}   < NACT_LIM);
      req_ncell = ADDR_W'(req_next_row) * ADDR_W'(GRID_COLS) + ADDR_W'(req_next_col);
      req_ccell = ADDR_W'(req_cur_row) * ADDR_W'(GRID_COLS) + ADDR_W'(req_cur_col);
   end

   assign status.req_bad    = !req_ok || (req_mask_eff == '0);
   assign status.clear_last = (clr_addr_ff == LAST_ADDR);

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         nbase_ff  <= req_ncell * ADDR_W'(NUM_ACTIONS);
         cidx_ff   <= req_ccell * ADDR_W'(NUM_ACTIONS) + ADDR_W'(req_action);
         reward_ff <= req_reward_value;
         mask_ff   <= req_mask_eff;
         err_ff    <= status.req_bad;
      end
   end

   // Advance the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear && !status.clear_last) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // Memory port selection
   always_comb begin
      rd_en = cmd.rd_next || cmd.rd_cur;
      raddr = cmd.rd_cur ? cidx_ff : (nbase_ff + ADDR_W'(cmd.move_idx));
      wr_en = cmd.clear || (cmd.commit && !err_ff);
      waddr = cmd.commit ? cidx_ff : clr_addr_ff;
      wdata = cmd.commit ? new_val : '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Track which move the returning read belongs to
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_next_ff <= 1'b0;
      end else begin
         rd_next_ff <= cmd.rd_next;
      end
   end

   always_ff @(posedge clock) begin
      rd_move_ff <= cmd.move_idx;
   end

   // Keep the largest entry among the available moves
   assign take = rd_next_ff && mask_ff[rd_move_ff] &&
                 (!found_ff || ($signed(rdata_ff) > best_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.start) begin
         found_ff <= 1'b0;
      end else if (rd_next_ff && mask_ff[rd_move_ff]) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff <= '0;
      end else if (take) begin
         best_ff <= $signed(rdata_ff);
      end
   end

   // gamma * best, then reward + round(gb) - q, then alpha * diff
   always_comb begin
      prod1_in  = $signed({1'b0, df_ff}) * best_ff;
      prod1_rnd = prod1_ff + PROD1_W'(32'sd32768);
      gb        = prod1_rnd[PROD1_W-1:FRAC_W];
      diff_in   = DIFF_W'(gb) + DIFF_W'(reward_ff) - DIFF_W'(q_ff);
      prod2_in  = $signed({1'b0, lr_ff}) * diff_ff;
      prod2_rnd = prod2_ff + PROD2_W'(32'sd32768);
      step      = prod2_rnd[PROD2_W-1:FRAC_W];
      sum       = SUM_W'(step) + SUM_W'(q_ff);
   end

   // Saturate to signed 32 bits
   always_comb begin
      if (sum[SUM_W-1:VALUE_W-1] == '0 || sum[SUM_W-1:VALUE_W-1] == '1) begin
         new_val = sum[VALUE_W-1:0];
      end else if (sum[SUM_W-1]) begin
         new_val = VAL_MIN;
      end else begin
         new_val = VAL_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         q_ff     <= $signed(rdata_ff);
         prod1_ff <= prod1_in;
      end
      if (cmd.diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.mul2) begin
         prod2_ff <= prod2_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         upd_out_ff  <= err_ff ? '0 : new_val;
         best_out_ff <= err_ff ? '0 : best_ff;
         err_out_ff  <= err_ff;
      end
   end

   assign rsp_updated_value = upd_out_ff;
   assign rsp_best_future   = best_out_ff;
   assign rsp_mask_error    = err_out_ff;

endmodule

FILE: dv/tb_q_table_update_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q_table_update_engine
// Self-checking bench for the Q table update engine. A shadow table tracks
// every accepted move and predicts the updated value, the best future value
// and the mask error flag. Results are checked in order. Learning rate and
// discount factor are changed between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb_q_table_update_engine;
   import qtue_pkg::*;

   localparam int GRID_ROWS       = 16;
   localparam int GRID_COLS       = 16;
   localparam int NUM_MOVES       = 4;
   localparam int TABLE_DEPTH     = GRID_ROWS * GRID_COLS * NUM_MOVES;
   localparam int SETTLE_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_MOVES     = 88;

   // Register indexes past the two real registers; writes there are dropped
   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_B = 2'd3;
   localparam logic [CSR_DATA_W-1:0] FRAC_FULL   = 16'hFFFF;
   localparam logic [CSR_DATA_W-1:0] FRAC_HALF   = 16'h8000;
   localparam logic [CSR_DATA_W-1:0] FRAC_ZERO   = 16'h0000;
   localparam logic [VALUE_W-1:0]    VALUE_MAX   = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0]    VALUE_MIN   = 32'h8000_0000;
   localparam logic [VALUE_W-1:0]    VALUE_ONE   = 32'h0001_0000;
   localparam logic [VALUE_W-1:0]    VALUE_NEG1  = 32'hFFFF_FFFF;
   localparam longint                SAT_HI      = 64'sd2147483647;
   localparam longint                SAT_LO      = -64'sd2147483648;
   localparam longint                HALF_LSB    = 64'sd32768;

   typedef struct packed {
      logic [COORD_W-1:0] cur_row;
      logic [COORD_W-1:0] cur_col;
      logic [MOVE_W-1:0]  action;
      logic [COORD_W-1:0] next_row;
      logic [COORD_W-1:0] next_col;
      logic [VALUE_W-1:0] reward;
      logic [MASK_W-1:0]  mask;
   } move_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] updated;
      logic [VALUE_W-1:0] best;
      logic               error;
   } q_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [COORD_W-1:0]        req_cur_row = '0;
   logic [COORD_W-1:0]        req_cur_col = '0;
   logic [MOVE_W-1:0]         req_action = '0;
   logic [COORD_W-1:0]        req_next_row = '0;
   logic [COORD_W-1:0]        req_next_col = '0;
   logic signed [VALUE_W-1:0] req_reward_value = '0;
   logic [MASK_W-1:0]         req_next_move_mask = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_updated_value;
   logic signed [VALUE_W-1:0] rsp_best_future;
   logic                      rsp_mask_error;

   // Shadow of the Q table and the two registers
   logic signed [VALUE_W-1:0] q_shadow [TABLE_DEPTH];
   longint                    alpha_shadow;
   longint                    gamma_shadow;

   move_req_type pending_moves [$];
   q_result_type expected_updates [$];
   move_req_type on_offer;
   q_result_type want;
   int        queued_count = 0;
   int        accepted_count = 0;
   int        mismatch_count = 0;
   int        results_seen = 0;
   int        burst_left = 0;
   int        gap_left = 0;
   int        hold_left = 0;
   int        idle_cycles = 0;
   logic [7:0] stall_phase = '0;

   q_table_update_engine #(
      .GRID_ROWS   (GRID_ROWS),
      .GRID_COLS   (GRID_COLS),
      .NUM_ACTIONS (NUM_MOVES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cur_row        (req_cur_row),
      .req_cur_col        (req_cur_col),
      .req_action         (req_action),
      .req_next_row       (req_next_row),
      .req_next_col       (req_next_col),
      .req_reward_value   (req_reward_value),
      .req_next_move_mask (req_next_move_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_updated_value  (rsp_updated_value),
      .rsp_best_future    (rsp_best_future),
      .rsp_mask_error     (rsp_mask_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one move to the shadow table and return the result it must give
   function automatic q_result_type predict_q_update(move_req_type m);
      int        nbase;
      int        cidx;
      int        i;
      longint    best;
      longint    q;
      longint    gb;
      longint    diff;
      longint    stp;
      longint    sum;
      bit        found;
      q_result_type r;
      found = 1'b0;
      best  = 0;
      nbase = (int'(m.next_row) * GRID_COLS + int'(m.next_col)) * NUM_MOVES;
      for (i = 0; i < NUM_MOVES && i < MASK_MOVES; i++) begin
         if (m.mask[i]) begin
            if (!found || longint'(q_shadow[nbase + i]) > best) begin
               best = q_shadow[nbase + i];
            end
            found = 1'b1;
         end
      end
      if (!found) begin
         r.updated = '0;
         r.best    = '0;
         r.error   = 1'b1;
         return r;
      end
      cidx = (int'(m.cur_row) * GRID_COLS + int'(m.cur_col)) * NUM_MOVES + int'(m.action);
      q    = q_shadow[cidx];
      // Round to nearest with ties upward: floor((x + half) / 2^16)
      gb   = (gamma_shadow * best + HALF_LSB) >>> FRAC_W;
      diff = longint'($signed(m.reward)) + gb - q;
      stp  = (alpha_shadow * diff + HALF_LSB) >>> FRAC_W;
      sum  = q + stp;
      if (sum > SAT_HI) begin
         sum = SAT_HI;
      end else if (sum < SAT_LO) begin
         sum = SAT_LO;
      end
      q_shadow[cidx] = VALUE_W'(sum);
      r.updated = VALUE_W'(sum);
      r.best    = VALUE_W'(best);
      r.error   = 1'b0;
      return r;
   endfunction

   function automatic void queue_move(input logic [COORD_W-1:0] cr, input logic [COORD_W-1:0] cc,
                                      input logic [MOVE_W-1:0] act,
                                      input logic [COORD_W-1:0] nr, input logic [COORD_W-1:0] nc,
                                      input logic [VALUE_W-1:0] rw, input logic [MASK_W-1:0] mk);
      move_req_type m;
      m.cur_row  = cr;
      m.cur_col  = cc;
      m.action   = act;
      m.next_row = nr;
      m.next_col = nc;
      m.reward   = rw;
      m.mask     = mk;
      pending_moves.insert(pending_moves.size(), m);
      queued_count++;
   endfunction

   task automatic queue_random_moves(int count);
      logic [COORD_W-1:0] cr;
      logic [COORD_W-1:0] cc;
      logic [COORD_W-1:0] nr;
      logic [COORD_W-1:0] nc;
      logic [MASK_W-1:0]  mk;
      logic [VALUE_W-1:0] rw;
      repeat (count) begin
         // Keep most moves on a small patch so entries get revisited and grow
         if ($urandom_range(0, 9) < 7) begin
            cr = COORD_W'($urandom_range(0, 3));
            cc = COORD_W'($urandom_range(0, 3));
            nr = COORD_W'($urandom_range(0, 3));
            nc = COORD_W'($urandom_range(0, 3));
         end else begin
            cr = COORD_W'($urandom);
            cc = COORD_W'($urandom);
            nr = COORD_W'($urandom);
            nc = COORD_W'($urandom);
         end
         mk = ($urandom_range(0, 9) == 0) ? '0 : MASK_W'($urandom_range(1, 15));
         case ($urandom_range(0, 7))
            0: rw = $urandom;
            1: rw = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
            default: rw = VALUE_W'($urandom_range(0, 1310720)) - 32'd655360;
         endcase
         queue_move(cr, cc, MOVE_W'($urandom_range(0, 3)), nr, nc, rw, mk);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == CSR_LEARNING_RATE) begin
         alpha_shadow = data;
      end else if (idx == CSR_DISCOUNT_FACTOR) begin
         gamma_shadow = data;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every queued move is accepted and every result is back
   task automatic wait_for_quiet();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_updates.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(string field_name, logic [VALUE_W-1:0] want_v,
                                logic [VALUE_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // Request driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_updates.insert(expected_updates.size(), predict_q_update(on_offer));
            accepted_count++;
         end
         // Hold an offered item until its transfer, otherwise pick the next step
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_moves.size() != 0) begin
               on_offer = pending_moves.pop_front();
               req_cur_row        <= on_offer.cur_row;
               req_cur_col        <= on_offer.cur_col;
               req_action         <= on_offer.action;
               req_next_row       <= on_offer.next_row;
               req_next_col       <= on_offer.next_col;
               req_reward_value   <= on_offer.reward;
               req_next_move_mask <= on_offer.mask;
               req_valid          <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check in order, stall on a rotating pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               $display("%0t: result with no update pending: expected none, actual %h %h %b",
                        $time, rsp_updated_value, rsp_best_future, rsp_mask_error);
               mismatch_count++;
            end else begin
               want = expected_updates.pop_front();
               compare_field("updated_value", want.updated, rsp_updated_value);
               compare_field("best_future", want.best, rsp_best_future);
               compare_field("mask_error", VALUE_W'(want.error), VALUE_W'(rsp_mask_error));
            end
            results_seen++;
            // Back up the engine while the driver keeps offering
            if (results_seen == 120 || results_seen == 450) begin
               hold_left = HOLD_OFF_CYCLES;
            end
         end
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_phase[6:5])
               2'd0: rsp_ready <= 1'b1;
               2'd1: rsp_ready <= 1'($urandom_range(0, 1));
               2'd2: rsp_ready <= (stall_phase[1:0] == 2'd0);
               default: rsp_ready <= !stall_phase[2];
            endcase
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int k;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         q_shadow[k] = '0;
      end
      alpha_shadow = LEARNING_RATE_RST;
      gamma_shadow = DISCOUNT_FACTOR_RST;

      // Corner moves under the reset rates: grid edges, every action, each mask bit
      queue_move(4'd0, 4'd0, 2'd0, 4'd0, 4'd0, '0, 4'b0000);
      queue_move(4'd15, 4'd15, 2'd3, 4'd15, 4'd15, VALUE_MAX, 4'b1111);
      queue_move(4'd0, 4'd15, 2'd1, 4'd15, 4'd0, VALUE_MIN, 4'b0001);
      queue_move(4'd15, 4'd0, 2'd2, 4'd0, 4'd15, VALUE_NEG1, 4'b0010);
      queue_move(4'd15, 4'd15, 2'd3, 4'd0, 4'd0, VALUE_ONE, 4'b0100);
      queue_move(4'd0, 4'd0, 2'd0, 4'd15, 4'd15, '0, 4'b1000);
      queue_move(4'd1, 4'd1, 2'd1, 4'd15, 4'd15, VALUE_ONE, 4'b1111);
      queue_move(4'd5, 4'd5, 2'd0, 4'd15, 4'd15, VALUE_MAX, 4'b0000);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_for_quiet();

      // Full rates: drive self loops into positive and negative saturation
      write_csr(CSR_LEARNING_RATE, FRAC_FULL);
      write_csr(CSR_DISCOUNT_FACTOR, FRAC_FULL);
      repeat (4) queue_move(4'd3, 4'd3, 2'd0, 4'd3, 4'd3, VALUE_MAX, 4'b0001);
      repeat (4) queue_move(4'd4, 4'd4, 2'd0, 4'd4, 4'd4, VALUE_MIN, 4'b0001);
      queue_move(4'd3, 4'd3, 2'd0, 4'd4, 4'd4, VALUE_MIN, 4'b0001);
      queue_move(4'd4, 4'd4, 2'd1, 4'd3, 4'd3, VALUE_MAX, 4'b0011);
      queue_move(4'd3, 4'd3, 2'd2, 4'd4, 4'd4, VALUE_MAX, 4'b1111);
      wait_for_quiet();

      // Random phases, one rate setting each
      for (k = 0; k < 8; k++) begin
         case (k)
            0: begin
               write_csr(CSR_LEARNING_RATE, FRAC_ZERO);
               write_csr(CSR_DISCOUNT_FACTOR, FRAC_ZERO);
            end
            1: write_csr(CSR_LEARNING_RATE, FRAC_FULL);
            2: begin
               write_csr(CSR_LEARNING_RATE, FRAC_ZERO);
               write_csr(CSR_DISCOUNT_FACTOR, FRAC_FULL);
            end
            3: begin
               write_csr(CSR_LEARNING_RATE, FRAC_HALF);
               write_csr(CSR_DISCOUNT_FACTOR, FRAC_HALF);
            end
            4: begin
               write_csr(CSR_SPARE_A, CSR_DATA_W'($urandom));
               write_csr(CSR_SPARE_B, CSR_DATA_W'($urandom));
               write_csr(CSR_LEARNING_RATE, CSR_DATA_W'($urandom));
               write_csr(CSR_DISCOUNT_FACTOR, CSR_DATA_W'($urandom));
            end
            5: begin
               write_csr(CSR_LEARNING_RATE, LEARNING_RATE_RST);
               write_csr(CSR_DISCOUNT_FACTOR, DISCOUNT_FACTOR_RST);
            end
            6: begin
               write_csr(CSR_LEARNING_RATE, CSR_DATA_W'($urandom));
               write_csr(CSR_DISCOUNT_FACTOR, CSR_DATA_W'($urandom));
            end
            default: begin
               write_csr(CSR_LEARNING_RATE, FRAC_FULL);
               write_csr(CSR_DISCOUNT_FACTOR, FRAC_FULL);
            end
         endcase
         queue_random_moves(PHASE_MOVES);
         wait_for_quiet();
      end

      if (mismatch_count == 0 && expected_updates.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/qtue_pkg.sv
hw/rtl/qtue_ctrl.sv
hw/rtl/qtue_datapath.sv
hw/rtl/q_table_update_engine.sv
dv/tb_q_table_update_engine.sv
